/* design/ruci_pkg.sv */
// ----------------------------------------------------------------------------
// ruci_pkg: shared types and helpers for the ray / unit cube intersection
// Holds the payload types of both channels, the stage enable bundle, the
// face codes and the fixed-point scale and saturation helpers.
// ----------------------------------------------------------------------------
package ruci_pkg;

	// Default number of fraction bits of the signed 32-bit fixed-point format.
	localparam int unsigned FRAC_BITS_DEFAULT = 16;

	// Epsilon is 1e-5 in the fixed-point format, rounded to nearest.
	localparam longint EPS_DIVISOR   = 100000;
	localparam longint EPS_ROUND_ADD = 50000;

	localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

	// Face codes of the result.
	localparam logic [2:0] FACE_POS_X = 3'd0;
	localparam logic [2:0] FACE_NEG_X = 3'd1;
	localparam logic [2:0] FACE_POS_Y = 3'd2;
	localparam logic [2:0] FACE_NEG_Y = 3'd3;
	localparam logic [2:0] FACE_POS_Z = 3'd4;
	localparam logic [2:0] FACE_NEG_Z = 3'd5;

	// Axis codes used when picking the dominant coordinate.
	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	typedef struct packed {
		logic signed [31:0] origin_x;
		logic signed [31:0] origin_y;
		logic signed [31:0] origin_z;
		logic signed [31:0] dir_x;
		logic signed [31:0] dir_y;
		logic signed [31:0] dir_z;
		logic signed [31:0] inv_dir_x;
		logic signed [31:0] inv_dir_y;
		logic signed [31:0] inv_dir_z;
		logic signed [31:0] t_lower;
		logic signed [31:0] t_upper;
	} ray_t;

	typedef struct packed {
		logic               hit;
		logic signed [31:0] t_hit;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
		logic        [2:0]  face;
		logic               front_facing;
	} res_t;

	// Load enables of the nine pipeline stages.
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
		logic s7;
		logic s8;
		logic s9;
	} pipe_en_t;

	// Clamp a 65-bit signed value to the signed 32-bit range.
	function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
		logic signed [31:0] r;
		if (v > 65'(S32_MAX)) begin
			r = S32_MAX;
		end else if (v < 65'(S32_MIN)) begin
			r = S32_MIN;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// Drop the fraction bits of a full product, rounding toward minus
	// infinity, and clamp the result to 32 bits.
	function automatic logic signed [31:0] qscale(input logic signed [64:0] prod,
			input int unsigned frac);
		logic signed [64:0] sh;
		sh = prod >>> frac;
		return sat32(sh);
	endfunction

endpackage

/* design/ruci_if.sv */
// ----------------------------------------------------------------------------
// ruci_if: valid/ready channels of the ray / unit cube intersection
// One channel carries rays into the block, the other carries results out.
// ----------------------------------------------------------------------------
interface ruci_ray_if;
	logic             valid;
	logic             ready;
	ruci_pkg::ray_t   data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ruci_res_if;
	logic             valid;
	logic             ready;
	ruci_pkg::res_t   data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* design/ruci_slab.sv */
// ----------------------------------------------------------------------------
// ruci_slab: entry and exit distance of one slab
// Three stages: plane offsets, full products, then scaling and saturation.
// ----------------------------------------------------------------------------
module ruci_slab #(
	parameter int unsigned FRAC_BITS = ruci_pkg::FRAC_BITS_DEFAULT
) (
	input  logic                clk,
	input  ruci_pkg::pipe_en_t  en,
	input  logic signed [31:0]  origin,
	input  logic signed [31:0]  inv_dir,
	output logic signed [31:0]  lo_s3,
	output logic signed [31:0]  hi_s3
);

	localparam longint HALF_L = longint'(1) << (FRAC_BITS - 1);
	localparam logic signed [32:0] HALF = 33'(HALF_L);

	logic signed [32:0] org_ext;
	logic signed [32:0] d_neg;
	logic signed [32:0] d_pos;
	logic signed [32:0] entry_s1;
	logic signed [32:0] exit_s1;
	logic signed [31:0] inv_s1;
	logic signed [64:0] entry_ext;
	logic signed [64:0] exit_ext;
	logic signed [64:0] inv_ext;
	logic signed [64:0] p_lo_s2;
	logic signed [64:0] p_hi_s2;

	assign org_ext = {origin[31], origin};
	assign d_neg   = -HALF - org_ext;
	assign d_pos   = HALF - org_ext;

	// A negative reciprocal swaps which plane is met first.
	always_ff @(posedge clk) begin
		if (en.s1) begin
			entry_s1 <= inv_dir[31] ? d_pos : d_neg;
			exit_s1  <= inv_dir[31] ? d_neg : d_pos;
			inv_s1   <= inv_dir;
		end
	end

	assign entry_ext = {{32{entry_s1[32]}}, entry_s1};
	assign exit_ext  = {{32{exit_s1[32]}}, exit_s1};
	assign inv_ext   = {{33{inv_s1[31]}}, inv_s1};

	always_ff @(posedge clk) begin
		if (en.s2) begin
			p_lo_s2 <= entry_ext * inv_ext;
			p_hi_s2 <= exit_ext * inv_ext;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			lo_s3 <= ruci_pkg::qscale(p_lo_s2, FRAC_BITS);
			hi_s3 <= ruci_pkg::qscale(p_hi_s2, FRAC_BITS);
		end
	end

endmodule

/* design/ruci_interval.sv */
// ----------------------------------------------------------------------------
// ruci_interval: slab combination and choice of the hit distance
// Narrows the x interval by the y slab, then by the z slab, and picks the
// entry or exit distance that lies in the ray's valid interval.
// ----------------------------------------------------------------------------
module ruci_interval #(
	parameter int unsigned FRAC_BITS = ruci_pkg::FRAC_BITS_DEFAULT
) (
	input  logic                clk,
	input  ruci_pkg::pipe_en_t  en,
	input  logic signed [31:0]  lo_x,
	input  logic signed [31:0]  hi_x,
	input  logic signed [31:0]  lo_y,
	input  logic signed [31:0]  hi_y,
	input  logic signed [31:0]  lo_z,
	input  logic signed [31:0]  hi_z,
	input  logic signed [31:0]  t_lower,
	input  logic signed [31:0]  t_upper,
	output logic                hit_s6,
	output logic signed [31:0]  t_s6
);

	localparam longint EPS_RND = ((longint'(1) << FRAC_BITS) + ruci_pkg::EPS_ROUND_ADD)
		/ ruci_pkg::EPS_DIVISOR;
	localparam logic signed [32:0] EPS = 33'((EPS_RND > 0) ? EPS_RND : longint'(1));

	logic               rej_y;
	logic               rej_z;
	logic signed [31:0] t0_s4;
	logic signed [31:0] t1_s4;
	logic               miss_s4;
	logic signed [31:0] lo_z_s4;
	logic signed [31:0] hi_z_s4;
	logic signed [32:0] tl_eps_s4;
	logic signed [31:0] tu_s4;
	logic signed [31:0] t0_s5;
	logic signed [31:0] t1_s5;
	logic               miss_s5;
	logic signed [32:0] tl_eps_s5;
	logic signed [31:0] tu_s5;
	logic               ok0;
	logic               ok1;

	assign rej_y = (lo_y > hi_x) || (hi_y < lo_x);

	always_ff @(posedge clk) begin
		if (en.s4) begin
			t0_s4     <= (lo_y > lo_x) ? lo_y : lo_x;
			t1_s4     <= (hi_y < hi_x) ? hi_y : hi_x;
			miss_s4   <= rej_y;
			lo_z_s4   <= lo_z;
			hi_z_s4   <= hi_z;
			tl_eps_s4 <= {t_lower[31], t_lower} + EPS;
			tu_s4     <= t_upper;
		end
	end

	assign rej_z = (lo_z_s4 > t1_s4) || (hi_z_s4 < t0_s4);

	always_ff @(posedge clk) begin
		if (en.s5) begin
			t0_s5     <= (lo_z_s4 > t0_s4) ? lo_z_s4 : t0_s4;
			t1_s5     <= (hi_z_s4 < t1_s4) ? hi_z_s4 : t1_s4;
			miss_s5   <= miss_s4 || rej_z;
			tl_eps_s5 <= tl_eps_s4;
			tu_s5     <= tu_s4;
		end
	end

	assign ok0 = !(($signed({t0_s5[31], t0_s5}) < tl_eps_s5) || (t0_s5 > tu_s5));
	assign ok1 = !(($signed({t1_s5[31], t1_s5}) < tl_eps_s5) || (t1_s5 > tu_s5));

	always_ff @(posedge clk) begin
		if (en.s6) begin
			hit_s6 <= !miss_s5 && (ok0 || ok1);
			t_s6   <= ok0 ? t0_s5 : t1_s5;
		end
	end

endmodule

/* design/ruci_point.sv */
// ----------------------------------------------------------------------------
// ruci_point: one coordinate of the hit point
// Multiplies direction by distance, then scales, adds the origin and clamps.
// ----------------------------------------------------------------------------
module ruci_point #(
	parameter int unsigned FRAC_BITS = ruci_pkg::FRAC_BITS_DEFAULT
) (
	input  logic                clk,
	input  ruci_pkg::pipe_en_t  en,
	input  logic signed [31:0]  origin,
	input  logic signed [31:0]  dir,
	input  logic signed [31:0]  t,
	output logic signed [31:0]  p_s8
);

	logic signed [64:0] dir_ext;
	logic signed [64:0] t_ext;
	logic signed [64:0] prod_s7;
	logic signed [31:0] org_s7;
	logic signed [31:0] step;
	logic signed [32:0] sum;

	assign dir_ext = {{33{dir[31]}}, dir};
	assign t_ext   = {{33{t[31]}}, t};

	always_ff @(posedge clk) begin
		if (en.s7) begin
			prod_s7 <= dir_ext * t_ext;
			org_s7  <= origin;
		end
	end

	assign step = ruci_pkg::qscale(prod_s7, FRAC_BITS);
	assign sum  = {org_s7[31], org_s7} + {step[31], step};

	always_ff @(posedge clk) begin
		if (en.s8) begin
			p_s8 <= ruci_pkg::sat32({{32{sum[32]}}, sum});
		end
	end

endmodule

/* design/ruci_face.sv */
// ----------------------------------------------------------------------------
// ruci_face: face classification and result register
// Picks the axis of largest absolute coordinate and forms the result item.
// ----------------------------------------------------------------------------
module ruci_face (
	input  logic                clk,
	input  ruci_pkg::pipe_en_t  en,
	input  logic                hit,
	input  logic signed [31:0]  t,
	input  logic signed [31:0]  p_x,
	input  logic signed [31:0]  p_y,
	input  logic signed [31:0]  p_z,
	input  logic signed [31:0]  d_x,
	input  logic signed [31:0]  d_y,
	input  logic signed [31:0]  d_z,
	output ruci_pkg::res_t      res_s9
);

	logic signed [32:0] ax;
	logic signed [32:0] ay;
	logic signed [32:0] az;
	logic        [1:0]  axis;
	logic signed [31:0] p_sel;
	logic signed [31:0] d_sel;
	logic        [2:0]  face_pos;
	logic        [2:0]  face_neg;
	ruci_pkg::res_t     res_d;

	assign ax = p_x[31] ? -{p_x[31], p_x} : {p_x[31], p_x};
	assign ay = p_y[31] ? -{p_y[31], p_y} : {p_y[31], p_y};
	assign az = p_z[31] ? -{p_z[31], p_z} : {p_z[31], p_z};

	// Ties go to the lower axis.
	always_comb begin
		priority if (ax >= ay && ax >= az) begin
			axis = ruci_pkg::AXIS_X;
		end else if (ay >= az) begin
			axis = ruci_pkg::AXIS_Y;
		end else begin
			axis = ruci_pkg::AXIS_Z;
		end
	end

	always_comb begin
		unique case (axis)
			ruci_pkg::AXIS_X: begin
				p_sel    = p_x;
				d_sel    = d_x;
				face_pos = ruci_pkg::FACE_POS_X;
				face_neg = ruci_pkg::FACE_NEG_X;
			end
			ruci_pkg::AXIS_Y: begin
				p_sel    = p_y;
				d_sel    = d_y;
				face_pos = ruci_pkg::FACE_POS_Y;
				face_neg = ruci_pkg::FACE_NEG_Y;
			end
			default: begin
				p_sel    = p_z;
				d_sel    = d_z;
				face_pos = ruci_pkg::FACE_POS_Z;
				face_neg = ruci_pkg::FACE_NEG_Z;
			end
		endcase
	end

	// A zero coordinate on the chosen axis counts as the negative face.
	always_comb begin
		res_d = '0;
		if (hit) begin
			res_d.hit     = 1'b1;
			res_d.t_hit   = t;
			res_d.point_x = p_x;
			res_d.point_y = p_y;
			res_d.point_z = p_z;
			if (p_sel > 32'sd0) begin
				res_d.face         = face_pos;
				res_d.front_facing = (d_sel <= 32'sd0);
			end else begin
				res_d.face         = face_neg;
				res_d.front_facing = (d_sel >= 32'sd0);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.s9) begin
			res_s9 <= res_d;
		end
	end

endmodule

/* design/ray_unit_cube_intersect_unit.sv */
// ----------------------------------------------------------------------------
// ray_unit_cube_intersect_unit: ray against the unit cube, slab method
// Fully pipelined intersection of rays with the cube of half-size 0.5
// centred at the origin, in signed fixed point.
// ----------------------------------------------------------------------------
// Usage. Rays arrive on the ray channel and results leave on the result
// channel; both are valid/ready channels and a transfer takes place on a
// rising clock edge with valid and ready both high. Every ray produces
// exactly one result, in order of arrival.
// Throughput is one ray per cycle while the result channel takes results,
// as each of the nine register stages then takes a new ray in every cycle:
// three for the slab distances (offsets, products, scaling), three for
// narrowing and choosing the distance, two for the hit point and one for
// the face and result register.
// Reset clears all stage valid bits; the data registers are not reset.
// When the receiver holds ready low, the unbroken run of full stages at the
// result end stops and keeps its contents, while stages above the first gap
// keep moving to fill it, so ray.ready only drops once every stage holds a ray.
// ----------------------------------------------------------------------------
module ray_unit_cube_intersect_unit #(
	parameter int unsigned FRAC_BITS = ruci_pkg::FRAC_BITS_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	ruci_ray_if.sink   ray,
	ruci_res_if.source result
);

	// Valid bit of each stage, index 1 to 9.
	logic [9:1] stage_vld_q;
	ruci_pkg::pipe_en_t en;

	// Ray fields follow the pipeline so that each part sees its own ray.
	ruci_pkg::ray_t ray_s1;
	ruci_pkg::ray_t ray_s2;
	ruci_pkg::ray_t ray_s3;
	ruci_pkg::ray_t ray_s4;
	ruci_pkg::ray_t ray_s5;
	ruci_pkg::ray_t ray_s6;
	ruci_pkg::ray_t ray_s7;
	ruci_pkg::ray_t ray_s8;

	logic signed [31:0] lo_x_s3;
	logic signed [31:0] hi_x_s3;
	logic signed [31:0] lo_y_s3;
	logic signed [31:0] hi_y_s3;
	logic signed [31:0] lo_z_s3;
	logic signed [31:0] hi_z_s3;
	logic               hit_s6;
	logic signed [31:0] t_s6;
	logic               hit_s7;
	logic               hit_s8;
	logic signed [31:0] t_s7;
	logic signed [31:0] t_s8;
	logic signed [31:0] px_s8;
	logic signed [31:0] py_s8;
	logic signed [31:0] pz_s8;
	ruci_pkg::res_t     res_s9;

	// A stage loads when it is empty or when its content moves on. The chain
	// runs from the result channel back to the ray channel.
	always_comb begin
		en.s9 = !stage_vld_q[9] || result.ready;
		en.s8 = !stage_vld_q[8] || en.s9;
		en.s7 = !stage_vld_q[7] || en.s8;
		en.s6 = !stage_vld_q[6] || en.s7;
		en.s5 = !stage_vld_q[5] || en.s6;
		en.s4 = !stage_vld_q[4] || en.s5;
		en.s3 = !stage_vld_q[3] || en.s4;
		en.s2 = !stage_vld_q[2] || en.s3;
		en.s1 = !stage_vld_q[1] || en.s2;
	end

	assign ray.ready    = en.s1;
	assign result.valid = stage_vld_q[9];
	assign result.data  = res_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else begin
			if (en.s1) stage_vld_q[1] <= ray.valid;
			if (en.s2) stage_vld_q[2] <= stage_vld_q[1];
			if (en.s3) stage_vld_q[3] <= stage_vld_q[2];
			if (en.s4) stage_vld_q[4] <= stage_vld_q[3];
			if (en.s5) stage_vld_q[5] <= stage_vld_q[4];
			if (en.s6) stage_vld_q[6] <= stage_vld_q[5];
			if (en.s7) stage_vld_q[7] <= stage_vld_q[6];
			if (en.s8) stage_vld_q[8] <= stage_vld_q[7];
			if (en.s9) stage_vld_q[9] <= stage_vld_q[8];
		end
	end

	always_ff @(posedge clk) begin
		if (en.s1) ray_s1 <= ray.data;
		if (en.s2) ray_s2 <= ray_s1;
		if (en.s3) ray_s3 <= ray_s2;
		if (en.s4) ray_s4 <= ray_s3;
		if (en.s5) ray_s5 <= ray_s4;
		if (en.s6) ray_s6 <= ray_s5;
		if (en.s7) begin
			ray_s7 <= ray_s6;
			hit_s7 <= hit_s6;
			t_s7   <= t_s6;
		end
		if (en.s8) begin
			ray_s8 <= ray_s7;
			hit_s8 <= hit_s7;
			t_s8   <= t_s7;
		end
	end

	// Slab distances, one unit per axis.
	ruci_slab #(.FRAC_BITS(FRAC_BITS)) u_slab_x (
		.clk     (clk),
		.en      (en),
		.origin  (ray.data.origin_x),
		.inv_dir (ray.data.inv_dir_x),
		.lo_s3   (lo_x_s3),
		.hi_s3   (hi_x_s3)
	);

	ruci_slab #(.FRAC_BITS(FRAC_BITS)) u_slab_y (
		.clk     (clk),
		.en      (en),
		.origin  (ray.data.origin_y),
		.inv_dir (ray.data.inv_dir_y),
		.lo_s3   (lo_y_s3),
		.hi_s3   (hi_y_s3)
	);

	ruci_slab #(.FRAC_BITS(FRAC_BITS)) u_slab_z (
		.clk     (clk),
		.en      (en),
		.origin  (ray.data.origin_z),
		.inv_dir (ray.data.inv_dir_z),
		.lo_s3   (lo_z_s3),
		.hi_s3   (hi_z_s3)
	);

	// Early rejection on y and z, then choice of entry or exit distance.
	ruci_interval #(.FRAC_BITS(FRAC_BITS)) u_interval (
		.clk     (clk),
		.en      (en),
		.lo_x    (lo_x_s3),
		.hi_x    (hi_x_s3),
		.lo_y    (lo_y_s3),
		.hi_y    (hi_y_s3),
		.lo_z    (lo_z_s3),
		.hi_z    (hi_z_s3),
		.t_lower (ray_s3.t_lower),
		.t_upper (ray_s3.t_upper),
		.hit_s6  (hit_s6),
		.t_s6    (t_s6)
	);

	// Hit point; computed for misses too and masked in the face stage.
	ruci_point #(.FRAC_BITS(FRAC_BITS)) u_point_x (
		.clk    (clk),
		.en     (en),
		.origin (ray_s6.origin_x),
		.dir    (ray_s6.dir_x),
		.t      (t_s6),
		.p_s8   (px_s8)
	);

	ruci_point #(.FRAC_BITS(FRAC_BITS)) u_point_y (
		.clk    (clk),
		.en     (en),
		.origin (ray_s6.origin_y),
		.dir    (ray_s6.dir_y),
		.t      (t_s6),
		.p_s8   (py_s8)
	);

	ruci_point #(.FRAC_BITS(FRAC_BITS)) u_point_z (
		.clk    (clk),
		.en     (en),
		.origin (ray_s6.origin_z),
		.dir    (ray_s6.dir_z),
		.t      (t_s6),
		.p_s8   (pz_s8)
	);

	ruci_face u_face (
		.clk    (clk),
		.en     (en),
		.hit    (hit_s8),
		.t      (t_s8),
		.p_x    (px_s8),
		.p_y    (py_s8),
		.p_z    (pz_s8),
		.d_x    (ray_s8.dir_x),
		.d_y    (ray_s8.dir_y),
		.d_z    (ray_s8.dir_z),
		.res_s9 (res_s9)
	);

	// A missed ray carries nothing but zeros.
	assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.data.hit) |->
		(result.data.t_hit == 32'sd0 && result.data.point_x == 32'sd0 &&
		 result.data.point_y == 32'sd0 && result.data.point_z == 32'sd0 &&
		 result.data.face == ruci_pkg::FACE_POS_X && !result.data.front_facing))
		else $error("miss result carries non-zero fields");

	// A positive x face code needs a positive x coordinate.
	assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.data.hit && result.data.face == ruci_pkg::FACE_POS_X) |->
		(result.data.point_x > 32'sd0))
		else $error("positive x face with non-positive x coordinate");

	// A hit never yields a face code outside the six faces.
	assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.data.hit) |->
		(result.data.face != 3'd6 && result.data.face != 3'd7))
		else $error("face code out of range");

	// While any stage is empty the ray channel must be ready.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(&stage_vld_q) |-> ray.ready)
		else $error("ray channel stalled with a free stage");

endmodule
